>>> sv/sqs_pkg.sv
// Shared types and constants for the sprite quad setup block.
package sqs_pkg;

    localparam int CORDIC_STEPS = 31;
    localparam int CORDIC_FRAC  = 30;
    localparam int DIV_STEPS    = 17;
    localparam int LANES        = 4;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 of a full turn.
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
    };

    localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    localparam int FLIP_H = 0;
    localparam int FLIP_V = 1;

    localparam logic [16:0] TEX_SAT = 17'h1FFFF;

    // One item as it travels down the cell chain.
    typedef struct packed {
        logic signed [33:0]       x;
        logic signed [33:0]       y;
        logic signed [33:0]       z;
        logic [1:0]               quad;
        logic [LANES-1:0][16:0]   rem;
        logic [LANES-1:0][16:0]   quo;
        logic [LANES-1:0]         sat;
        logic signed [39:0]       oxp;
        logic signed [39:0]       oyp;
        logic signed [32:0]       sw;
        logic signed [32:0]       sh;
        logic signed [23:0]       pos_x;
        logic signed [23:0]       pos_y;
        logic [1:0]               flip;
    } sqs_item_t;

    // Four finished corners of one quad.
    typedef struct packed {
        logic [3:0][23:0] cx;
        logic [3:0][23:0] cy;
        logic [1:0][16:0] u;
        logic [1:0][16:0] v;
    } sqs_quad_t;

endpackage

>>> sv/sqs_cell.sv
// Chain cell: CORDIC micro-rotation and, if STEP < DIV_STEPS, a quotient bit per lane.
module sqs_cell #(
    parameter int STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  sqs_pkg::sqs_item_t in_item,
    input  logic [15:0]        tex_width,
    input  logic [15:0]        tex_height,
    output logic               out_vld,
    output sqs_pkg::sqs_item_t out_item
);
    import sqs_pkg::*;

    sqs_item_t          item_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic [16:0]        dvs;
    logic [16:0]        r;

    always_comb
    begin
        item_next = in_item;
        dx = in_item.y >>> STEP;
        dy = in_item.x >>> STEP;
        at = $signed({2'b00, ATAN_TURN[STEP]});
        if (!in_item.z[33])
        begin
            item_next.x = in_item.x - dx;
            item_next.y = in_item.y + dy;
            item_next.z = in_item.z - at;
        end
        else
        begin
            item_next.x = in_item.x + dx;
            item_next.y = in_item.y - dy;
            item_next.z = in_item.z + at;
        end
        dvs = 17'd0;
        r = 17'd0;
        if (STEP < DIV_STEPS)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                dvs = (i < 2) ? {1'b0, tex_width} : {1'b0, tex_height};
                r = (STEP == 0) ? in_item.rem[i] : {in_item.rem[i][15:0], 1'b0};
                if (r >= dvs)
                begin
                    item_next.rem[i] = r - dvs;
                    item_next.quo[i] = {in_item.quo[i][15:0], 1'b1};
                end
                else
                begin
                    item_next.rem[i] = r;
                    item_next.quo[i] = {in_item.quo[i][15:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld <= 1'b0;
        end
        else if (en)
        begin
            out_vld <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_item <= item_next;
        end
    end

endmodule

>>> sv/sqs_corner.sv
// Corner arithmetic after the chain: local corners, trig rounding, products, sums.
module sqs_corner #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  sqs_pkg::sqs_item_t in_item,
    output logic               out_vld,
    output sqs_pkg::sqs_quad_t out_quad
);
    import sqs_pkg::*;

    localparam int LW = 34;
    localparam int CW = TRIG_FRAC_BITS + 2;
    localparam int PW = LW + CW;
    localparam int AW = PW + 2;
    localparam int SH = CORDIC_FRAC - TRIG_FRAC_BITS;
    localparam logic signed [33:0]   TRIG_HALF = 34'sd1 <<< (SH - 1);
    localparam logic signed [AW-1:0] PROD_HALF = AW'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] MAX24 = AW'(8388607);
    localparam logic signed [AW-1:0] MIN24 = -AW'(8388608);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Stage one: local corners and rounded, quadrant-rotated trig.
    logic signed [39:0]   oxr;
    logic signed [39:0]   oyr;
    logic signed [LW-1:0] ox;
    logic signed [LW-1:0] oy;
    logic signed [33:0]   cr;
    logic signed [33:0]   sr;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] s1;
    logic signed [CW-1:0] cos_next;
    logic signed [CW-1:0] sin_next;
    logic [16:0]          lane [LANES];
    logic [1:0][16:0]     u_next;
    logic [1:0][16:0]     v_next;

    logic                 s1_vld_reg;
    logic signed [LW-1:0] lx_reg [2];
    logic signed [LW-1:0] ly_reg [2];
    logic signed [CW-1:0] cos_reg;
    logic signed [CW-1:0] sin_reg;
    logic signed [23:0]   px1_reg;
    logic signed [23:0]   py1_reg;
    logic [1:0][16:0]     u1_reg;
    logic [1:0][16:0]     v1_reg;

    always_comb
    begin
        oxr = (in_item.oxp + 40'sd128) >>> 8;
        oyr = (in_item.oyp + 40'sd128) >>> 8;
        ox = LW'(oxr);
        oy = LW'(oyr);
        cr = (in_item.x + TRIG_HALF) >>> SH;
        sr = (in_item.y + TRIG_HALF) >>> SH;
        c1 = CW'(cr);
        s1 = CW'(sr);
        case (in_item.quad)
            QUAD_0:
            begin
                cos_next = c1;
                sin_next = s1;
            end
            QUAD_1:
            begin
                cos_next = -s1;
                sin_next = c1;
            end
            QUAD_2:
            begin
                cos_next = -c1;
                sin_next = -s1;
            end
            default:
            begin
                cos_next = s1;
                sin_next = -c1;
            end
        endcase
        for (int i = 0; i < LANES; i++)
        begin
            lane[i] = in_item.sat[i] ? TEX_SAT : in_item.quo[i];
        end
        u_next[0] = in_item.flip[FLIP_H] ? lane[1] : lane[0];
        u_next[1] = in_item.flip[FLIP_H] ? lane[0] : lane[1];
        v_next[0] = in_item.flip[FLIP_V] ? lane[3] : lane[2];
        v_next[1] = in_item.flip[FLIP_V] ? lane[2] : lane[3];
    end

    // Stage two: the eight products.
    logic                 s2_vld_reg;
    logic signed [PW-1:0] xc_reg [2];
    logic signed [PW-1:0] xs_reg [2];
    logic signed [PW-1:0] yc_reg [2];
    logic signed [PW-1:0] ys_reg [2];
    logic signed [23:0]   px2_reg;
    logic signed [23:0]   py2_reg;
    logic [1:0][16:0]     u2_reg;
    logic [1:0][16:0]     v2_reg;

    // Stage three: corner sums, rounding, translation, saturation.
    sqs_quad_t            quad_next;
    logic                 xi;
    logic                 yi;
    logic signed [AW-1:0] sum_x;
    logic signed [AW-1:0] sum_y;
    logic signed [AW-1:0] tot_x;
    logic signed [AW-1:0] tot_y;

    always_comb
    begin
        quad_next.u = u2_reg;
        quad_next.v = v2_reg;
        quad_next.cx = '0;
        quad_next.cy = '0;
        xi = 1'b0;
        yi = 1'b0;
        sum_x = '0;
        sum_y = '0;
        tot_x = '0;
        tot_y = '0;
        for (int k = 0; k < 4; k++)
        begin
            xi = (k == 1) || (k == 2);
            yi = (k >= 2);
            sum_x = AW'(xc_reg[xi]) - AW'(ys_reg[yi]);
            sum_y = AW'(xs_reg[xi]) + AW'(yc_reg[yi]);
            tot_x = ((sum_x + PROD_HALF) >>> TRIG_FRAC_BITS) + AW'(px2_reg);
            tot_y = ((sum_y + PROD_HALF) >>> TRIG_FRAC_BITS) + AW'(py2_reg);
            if (tot_x > MAX24)
                quad_next.cx[k] = 24'h7FFFFF;
            else if (tot_x < MIN24)
                quad_next.cx[k] = 24'h800000;
            else
                quad_next.cx[k] = tot_x[23:0];
            if (tot_y > MAX24)
                quad_next.cy[k] = 24'h7FFFFF;
            else if (tot_y < MIN24)
                quad_next.cy[k] = 24'h800000;
            else
                quad_next.cy[k] = tot_y[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            out_vld    <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            out_vld    <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx_reg[0] <= -ox;
            lx_reg[1] <= LW'(in_item.sw) - ox;
            ly_reg[0] <= -oy;
            ly_reg[1] <= LW'(in_item.sh) - oy;
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
            px1_reg   <= in_item.pos_x;
            py1_reg   <= in_item.pos_y;
            u1_reg    <= u_next;
            v1_reg    <= v_next;
            for (int i = 0; i < 2; i++)
            begin
                xc_reg[i] <= lx_reg[i] * cos_reg;
                xs_reg[i] <= lx_reg[i] * sin_reg;
                yc_reg[i] <= ly_reg[i] * cos_reg;
                ys_reg[i] <= ly_reg[i] * sin_reg;
            end
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            u2_reg   <= u1_reg;
            v2_reg   <= v1_reg;
            out_quad <= quad_next;
        end
    end

endmodule

>>> sv/sprite_quad_setup_top.sv
// Top level of the sprite quad setup block: input stage, cell chain, corner math, output.
//
// Each accepted sprite item yields four corner items in the order top-left, top-right,
// bottom-right, bottom-left, the last one flagged by last_corner. An item first passes
// an input stage that forms the scaled origin and size products, then a chain of 31
// identical cells; every cell performs one CORDIC micro-rotation for the sine and
// cosine and, in the first 17 cells, one quotient bit of each of the four texture
// coordinate divisions. Three more stages build the local corners, multiply them by
// the rotation and translate and saturate them, and an output register hands out the
// four corners. The block takes new items while the chain can move, but its sustained
// input rate is set by the four corner items that share the single output register;
// items queue in the chain meanwhile. Texture size registers must only be written
// while no item is in flight.
module sprite_quad_setup_top #(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        rect_left,
    input  logic [15:0]        rect_top,
    input  logic [15:0]        rect_right,
    input  logic [15:0]        rect_bottom,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    input  logic signed [23:0] origin_x,
    input  logic signed [23:0] origin_y,
    input  logic [15:0]        rotation_angle,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic [1:0]         flip_mode,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         corner_index,
    output logic signed [23:0] corner_x,
    output logic signed [23:0] corner_y,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic               last_corner
);
    import sqs_pkg::*;

    localparam int DROP = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
    localparam logic [15:0] ANGLE_MASK = 16'hFFFF << DROP;

    // Texture size registers.
    logic [15:0] tex_width_reg;
    logic [15:0] tex_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= 16'd256;
            tex_height_reg <= 16'd256;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == REG_TEX_WIDTH)
                tex_width_reg <= cfg_data;
            else if (cfg_index == REG_TEX_HEIGHT)
                tex_height_reg <= cfg_data;
        end
    end

    // Global advance: the whole pipeline moves unless its last stage holds an item
    // that the output register cannot take yet.
    logic      en;
    logic      corner_vld;
    sqs_quad_t corner_quad;
    logic      holding_reg;
    logic [1:0] k_reg;
    logic      tail_ready;
    logic      out_take;

    assign out_take   = holding_reg && !out_stall;
    assign tail_ready = !holding_reg || (out_take && (k_reg == CORNER_LAST));
    assign en         = !corner_vld || tail_ready;
    assign in_stall   = !en;

    // Input stage: angle reduction to a quadrant and residual, scale products and
    // the starting remainders and saturation flags of the four divisions.
    logic [31:0]        turn;
    logic [31:0]        turn_rnd;
    logic [31:0]        zres;
    logic signed [16:0] dw;
    logic signed [16:0] dh;
    logic [15:0]        edges [LANES];
    logic [15:0]        sizes [LANES];
    sqs_item_t          front_next;

    always_comb
    begin
        turn = {rotation_angle & ANGLE_MASK, 16'h0000};
        turn_rnd = turn + 32'h2000_0000;
        zres = turn - {turn_rnd[31:30], 30'd0};
        dw = $signed({1'b0, rect_right}) - $signed({1'b0, rect_left});
        dh = $signed({1'b0, rect_bottom}) - $signed({1'b0, rect_top});
        edges[0] = rect_left;
        edges[1] = rect_right;
        edges[2] = rect_top;
        edges[3] = rect_bottom;
        sizes[0] = tex_width_reg;
        sizes[1] = tex_width_reg;
        sizes[2] = tex_height_reg;
        sizes[3] = tex_height_reg;
        front_next.x = CORDIC_GAIN;
        front_next.y = '0;
        front_next.z = 34'(signed'(zres));
        front_next.quad = turn_rnd[31:30];
        for (int i = 0; i < LANES; i++)
        begin
            front_next.rem[i] = {1'b0, edges[i]};
            front_next.quo[i] = '0;
            // A quotient of two or more, or a zero size, saturates the coordinate.
            front_next.sat[i] = {1'b0, edges[i]} >= {sizes[i], 1'b0};
        end
        front_next.oxp = origin_x * scale_x;
        front_next.oyp = origin_y * scale_y;
        front_next.sw = dw * scale_x;
        front_next.sh = dh * scale_y;
        front_next.pos_x = pos_x;
        front_next.pos_y = pos_y;
        front_next.flip = flip_mode;
    end

    logic      chain_vld  [CORDIC_STEPS+1];
    sqs_item_t chain_item [CORDIC_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_vld[0] <= 1'b0;
        end
        else if (en)
        begin
            chain_vld[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chain_item[0] <= front_next;
        end
    end

    // The cell chain.
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        sqs_cell #(
            .STEP(g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .in_vld     (chain_vld[g]),
            .in_item    (chain_item[g]),
            .tex_width  (tex_width_reg),
            .tex_height (tex_height_reg),
            .out_vld    (chain_vld[g+1]),
            .out_item   (chain_item[g+1])
        );
    end

    sqs_corner #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_corner (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (chain_vld[CORDIC_STEPS]),
        .in_item  (chain_item[CORDIC_STEPS]),
        .out_vld  (corner_vld),
        .out_quad (corner_quad)
    );

    // Output register: holds one quad and steps through its four corners.
    sqs_quad_t quad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg <= 1'b0;
            k_reg       <= CORNER_FIRST;
        end
        else
        begin
            if (out_take)
                k_reg <= k_reg + 2'd1;
            if (tail_ready)
                holding_reg <= corner_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_ready && corner_vld)
        begin
            quad_reg <= corner_quad;
        end
    end

    assign out_valid    = holding_reg;
    assign corner_index = k_reg;
    assign corner_x     = quad_reg.cx[k_reg];
    assign corner_y     = quad_reg.cy[k_reg];
    assign tex_u        = quad_reg.u[k_reg[0] ^ k_reg[1]];
    assign tex_v        = quad_reg.v[k_reg[1]];
    assign last_corner  = (k_reg == CORNER_LAST);

    // A quad always starts at its top-left corner.
    a_idle_at_tl: assert property (@(posedge clk) disable iff (!rst_n)
        !holding_reg |-> k_reg == CORNER_FIRST)
        else $error("output idle away from the first corner");

    // A taken corner that is not the last is followed by the next corner.
    a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !last_corner |=> out_valid && corner_index == $past(corner_index) + 2'd1)
        else $error("corner sequence broken");

    // The pipeline only halts while a finished item waits for the output register.
    a_halt_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> corner_vld && holding_reg)
        else $error("pipeline halted without cause");

    // Taking the last corner with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && last_corner && !corner_vld |=> !out_valid)
        else $error("output item invented");

endmodule

>>> dv/tb_sprite_quad_setup_top.sv
// Sprite quad setup testbench: directed and random sprites checked against a built-in predictor.
`timescale 1ns / 100ps

module tb_sprite_quad_setup_top;
    import sqs_pkg::*;

    localparam int ANGLE_W = 16;
    localparam int TFRAC   = 15;

    // Register index that names no register.
    localparam logic [1:0] REG_NONE = 2'd3;

    // One sprite description as offered on the input channel.
    typedef struct packed {
        logic [15:0]        left;
        logic [15:0]        top;
        logic [15:0]        right;
        logic [15:0]        bottom;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic [15:0]        angle;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [1:0]         flip;
    } sprite_t;

    // One corner as it should leave the block.
    typedef struct packed {
        logic [1:0]         idx;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [16:0]        u;
        logic [16:0]        v;
        logic               last;
    } corner_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    sprite_t drv = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] corner_index;
    logic signed [23:0] corner_x, corner_y;
    logic [16:0] tex_u, tex_v;
    logic last_corner;

    sprite_t pending_sprites[$];
    corner_t expected_corners[$];
    logic [15:0] tex_w = 16'd256;
    logic [15:0] tex_h = 16'd256;
    int errors = 0;
    bit calm = 1'b0;          // no idling on either side while set
    int hold_off = 0;         // receiver hold-off cycles left

    // Stall as seen at the last rising edge, so acceptance is judged on sampled values.
    logic in_stall_q = 1'b1;

    sprite_quad_setup_top #(.ANGLE_BITS(ANGLE_W), .TRIG_FRAC_BITS(TFRAC)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .rect_left(drv.left), .rect_top(drv.top), .rect_right(drv.right),
        .rect_bottom(drv.bottom), .scale_x(drv.sx), .scale_y(drv.sy),
        .origin_x(drv.ox), .origin_y(drv.oy), .rotation_angle(drv.angle),
        .pos_x(drv.px), .pos_y(drv.py), .flip_mode(drv.flip),
        .out_valid(out_valid), .out_stall(out_stall),
        .corner_index(corner_index), .corner_x(corner_x), .corner_y(corner_y),
        .tex_u(tex_u), .tex_v(tex_v), .last_corner(last_corner)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Arctangent of 2^-i in units of 2^-32 of a full turn.
    function automatic longint atan_step(int i);
        longint tbl[31] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
            81, 41, 20, 10, 5, 3, 1, 1};
        return tbl[i];
    endfunction

    // Arithmetic shift right floors, and adding half first gives round half up.
    function automatic longint round_half_up(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > 8388607) return 24'sh7FFFFF;
        if (v < -8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic logic [16:0] texel_ratio(logic [15:0] edge_px, logic [15:0] size);
        longint q;
        if (size == 0) return TEX_SAT;
        q = (longint'(edge_px) << 16) / longint'(size);
        return (q > 131071) ? TEX_SAT : q[16:0];
    endfunction

    // Sine and cosine at TFRAC fraction bits: quadrant fold, then 31 CORDIC steps.
    task automatic sin_cos(input logic [15:0] angle, output longint cs, output longint sn);
        logic [31:0] turn;
        logic [1:0] q;
        logic [31:0] zr;
        longint x, y, z, dx, dy, c, s;
        int drop;
        drop = (ANGLE_W >= 16) ? 0 : 16 - ANGLE_W;
        turn = {((angle >> drop) << drop), 16'h0};
        q = 2'((turn + 32'h2000_0000) >> 30);
        zr = turn - {q, 30'h0};
        z = longint'(signed'(zr));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 31; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = round_half_up(x, 30 - TFRAC);
        s = round_half_up(y, 30 - TFRAC);
        case (q)
            2'd0: begin cs = c;  sn = s;  end
            2'd1: begin cs = -s; sn = c;  end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endtask

    // Works out the four corners of a sprite and appends them to the expected store.
    task automatic predict_quad(input sprite_t sp);
        longint ox, oy, sw, sh, c, s, rx, ry;
        longint lx[4], ly[4];
        logic [16:0] u0, u1, v0, v1, t;
        logic [16:0] us[4], vs[4];
        corner_t cr;
        ox = round_half_up(longint'(sp.ox) * longint'(sp.sx), 8);
        oy = round_half_up(longint'(sp.oy) * longint'(sp.sy), 8);
        sw = (longint'(sp.right) - longint'(sp.left)) * longint'(sp.sx);
        sh = (longint'(sp.bottom) - longint'(sp.top)) * longint'(sp.sy);
        u0 = texel_ratio(sp.left, tex_w);
        u1 = texel_ratio(sp.right, tex_w);
        v0 = texel_ratio(sp.top, tex_h);
        v1 = texel_ratio(sp.bottom, tex_h);
        sin_cos(sp.angle, c, s);
        if (sp.flip[FLIP_H])
        begin
            t = u0; u0 = u1; u1 = t;
        end
        if (sp.flip[FLIP_V])
        begin
            t = v0; v0 = v1; v1 = t;
        end
        lx[0] = -ox;      ly[0] = -oy;      us[0] = u0; vs[0] = v0;
        lx[1] = sw - ox;  ly[1] = -oy;      us[1] = u1; vs[1] = v0;
        lx[2] = sw - ox;  ly[2] = sh - oy;  us[2] = u1; vs[2] = v1;
        lx[3] = -ox;      ly[3] = sh - oy;  us[3] = u0; vs[3] = v1;
        for (int k = 0; k < 4; k++)
        begin
            rx = round_half_up(lx[k] * c - ly[k] * s, TFRAC);
            ry = round_half_up(lx[k] * s + ly[k] * c, TFRAC);
            cr.idx = k[1:0];
            cr.cx = clamp24(longint'(sp.px) + rx);
            cr.cy = clamp24(longint'(sp.py) + ry);
            cr.u = us[k];
            cr.v = vs[k];
            cr.last = (k[1:0] == CORNER_LAST);
            expected_corners.push_back(cr);
        end
    endtask

    // The driver offers the next pending sprite and keeps it steady while stalled.
    // A sprite is predicted at the edge where it is accepted, so that register
    // writes between phases apply to exactly the sprites that follow them.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall_q)
            begin
                // accepted at the last rising edge; choose what comes next
                if (pending_sprites.size() > 0 && (calm || $urandom_range(99) >= 6))
                begin
                    drv <= pending_sprites.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            else if (!in_valid && pending_sprites.size() > 0 &&
                     (calm || $urandom_range(99) >= 6))
            begin
                drv <= pending_sprites.pop_front();
                in_valid <= 1'b1;
            end
            if (hold_off > 0)
                out_stall <= 1'b1;
            else
                out_stall <= !calm && ($urandom_range(99) < 6);
        end
    end

    always @(posedge clk)
    begin
        in_stall_q <= in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            predict_quad(drv);
        end
    end

    // The receiver hold-off counts down once per cycle.
    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // The monitor compares every accepted corner with the oldest expectation.
    always @(posedge clk)
    begin
        corner_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_corners.size() == 0)
            begin
                $error("corner item with no expectation waiting");
                errors++;
            end
            else
            begin
                want = expected_corners.pop_front();
                if (corner_index !== want.idx)
                begin
                    $error("corner_index expected %0d got %0d", want.idx, corner_index);
                    errors++;
                end
                if (corner_x !== want.cx)
                begin
                    $error("corner_x expected %0d got %0d", want.cx, corner_x);
                    errors++;
                end
                if (corner_y !== want.cy)
                begin
                    $error("corner_y expected %0d got %0d", want.cy, corner_y);
                    errors++;
                end
                if (tex_u !== want.u)
                begin
                    $error("tex_u expected %0d got %0d", want.u, tex_u);
                    errors++;
                end
                if (tex_v !== want.v)
                begin
                    $error("tex_v expected %0d got %0d", want.v, tex_v);
                    errors++;
                end
                if (last_corner !== want.last)
                begin
                    $error("last_corner expected %0d got %0d", want.last, last_corner);
                    errors++;
                end
            end
        end
    end

    function automatic sprite_t random_sprite();
        sprite_t sp;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        sp = raw[$bits(sprite_t)-1:0];
        // Mostly moderate sizes and scales so the corners stay in range;
        // the rest uses full random values and exercises saturation.
        if ($urandom_range(99) < 75)
        begin
            sp.right  = 16'(sp.left + $urandom_range(300) - 60);
            sp.bottom = 16'(sp.top + $urandom_range(300) - 60);
            sp.sx = 16'($signed($urandom_range(1024)) - 256);
            sp.sy = 16'($signed($urandom_range(1024)) - 256);
            sp.ox = 24'($signed($urandom_range(20000)) - 10000);
            sp.oy = 24'($signed($urandom_range(20000)) - 10000);
            sp.px = 24'($signed($urandom_range(400000)) - 200000);
            sp.py = 24'($signed($urandom_range(400000)) - 200000);
        end
        return sp;
    endfunction

    function automatic sprite_t edge_sprite(int n);
        sprite_t sp;
        sp = '0;
        sp.right = 16'd64;
        sp.bottom = 16'd32;
        sp.sx = 16'sh0100;
        sp.sy = 16'sh0100;
        case (n)
            1: begin sp.left = 16'hFFFF; sp.top = 16'hFFFF;
                     sp.right = 16'hFFFF; sp.bottom = 16'hFFFF; end
            2: begin sp.left = 16'd100; sp.right = 16'd10; end        // inverted width
            3: begin sp.top = 16'd90; sp.bottom = 16'd5; end          // inverted height
            4: begin sp.sx = 16'sh7FFF; sp.sy = 16'sh7FFF; end
            5: begin sp.sx = 16'sh8000; sp.sy = 16'sh8000; end
            6: begin sp.ox = 24'sh7FFFFF; sp.oy = 24'sh800000; end
            7: begin sp.px = 24'sh7FFFFF; sp.py = 24'sh7FFFFF; end
            8: begin sp.px = 24'sh800000; sp.py = 24'sh800000; end
            9: sp.angle = 16'h4000;
            10: sp.angle = 16'h8000;
            11: sp.angle = 16'hC000;
            12: sp.angle = 16'hFFFF;
            13: sp.angle = 16'h2000;   // exactly on a quadrant boundary
            14: sp.flip = 2'd1;
            15: sp.flip = 2'd2;
            16: sp.flip = 2'd3;
            17: begin sp.left = 16'hFFFF; sp.right = 16'hFFFF; sp.sx = 16'sh8000;
                      sp.ox = 24'sh800000; sp.px = 24'sh800000; sp.angle = 16'h6000; end
            default: ;
        endcase
        return sp;
    endfunction

    // Writes one texture size register while the block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_TEX_WIDTH) tex_w = val;
        else if (idx == REG_TEX_HEIGHT) tex_h = val;
    endtask

    // Waits until every queued sprite is accepted and every corner has come out.
    task automatic drain();
        while (pending_sprites.size() > 0 || in_valid || expected_corners.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] sizes[5];
        sizes = '{16'd256, 16'd1, 16'hFFFF, 16'd0, 16'd0};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed sprites at reset texture sizes.
        for (int n = 0; n < 18; n++)
            pending_sprites.push_back(edge_sprite(n));
        drain();

        // Random phases, each with its own texture sizes, one with a long hold-off.
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 4)
            begin
                write_reg(REG_TEX_WIDTH, sizes[ph + 1]);
                write_reg(REG_TEX_HEIGHT, sizes[(ph + 2) % 5]);
            end
            else
            begin
                write_reg(REG_TEX_WIDTH, 16'($urandom_range(65535, 1)));
                write_reg(REG_TEX_HEIGHT, 16'($urandom_range(65535, 1)));
            end
            // The out-of-range index must be ignored.
            write_reg(REG_NONE, 16'h1234);
            calm = (ph == 2);
            for (int k = 0; k < 80; k++)
                pending_sprites.push_back(random_sprite());
            if (ph == 3)
            begin
                repeat (5) @(posedge clk);
                hold_off = 400;
            end
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end
endmodule
